// ----- rtl/core/nlp_pkg.sv -----
// shared constants and codes for the nearest rail projection block
package nlp_pkg;

  localparam int NLP_MAX_RAILS  = 64;
  localparam int NLP_COORD_BITS = 16;
  localparam int NLP_IDX_BITS   = 6;
  localparam int NLP_CNT_BITS   = 7;
  localparam int NLP_MUL_DIGIT  = 12;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } nlp_op_e;

endpackage

// ----- rtl/core/nlp_ram.sv -----
// generic single write port, single read port ram with registered read
module nlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/nlp_mul.sv -----
// multi-cycle unsigned multiplier, one digit of the b operand per cycle
module nlp_mul #(
  parameter int A_W = 66,
  parameter int B_W = 33,
  parameter int DIG = nlp_pkg::NLP_MUL_DIGIT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic [A_W+B_W-1:0] prod_o,
  output logic               done_o
);
  import nlp_pkg::*;

  localparam int NCH = (B_W + DIG - 1) / DIG;
  localparam int PBW = NCH * DIG;
  localparam int RW  = A_W + PBW;
  localparam int CNW = $clog2(NCH + 1);

  logic [A_W-1:0]     a_q;
  logic [PBW-1:0]     b_q;
  logic [RW-1:0]      acc_q;
  logic [CNW-1:0]     cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [A_W+DIG-1:0] pp;

  // partial product of the current top digit
  assign pp = a_q * b_q[PBW-1 -: DIG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNW'(NCH);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNW'(1);
        if (cnt_q == CNW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= PBW'(b_i);
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= (acc_q << DIG) + RW'(pp);
      b_q   <= b_q << DIG;
    end
  end

  assign prod_o = acc_q[A_W+B_W-1:0];
  assign done_o = done_q;

endmodule

// ----- rtl/core/nlp_div.sv -----
// restoring divider, one quotient bit per cycle
module nlp_div #(
  parameter int N_W = 49,
  parameter int D_W = 33
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] num_i,
  input  logic [D_W-1:0] den_i,
  output logic [N_W-1:0] quo_o,
  output logic           done_o
);

  localparam int CNW = $clog2(N_W + 1);

  logic [N_W-1:0] num_q;
  logic [D_W-1:0] den_q;
  logic [D_W-1:0] rem_q;
  logic [CNW-1:0] cnt_q;
  logic           busy_q;
  logic           done_q;
  logic [D_W:0]   trial;
  logic [D_W:0]   diff;
  logic           ge;

  assign trial = {rem_q, num_q[N_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNW'(N_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNW'(1);
        if (cnt_q == CNW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
      num_q <= {num_q[N_W-2:0], ge};
    end
  end

  assign quo_o  = num_q;
  assign done_o = done_q;

endmodule

// ----- rtl/core/nearest_line_projection.sv -----
// top level: rail table, nearest rail scan and projection sequencer
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------------------
//  cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_data_i (rail_count)
//  in      | in        | in_valid_i / in_ready_o   | operation, rail_index, start, end, point
//  out     | out       | out_valid_o / out_ready_i | found, nearest_rail, near_x/y, load_ack
//
// a load writes one rail word. a query scans the rails in order, then projects onto the best:
// a usable rail takes seven multiplies (five for the first usable one), a zero-length rail
// four; projection adds four multiplies and two divides, all on the one shared serial
// multiplier and the bit-serial divider. rail table is one ram word per rail, and each
// word arrives in the cycle after its address.
// reset clears control only; the table is undefined until loaded. the next item is
// taken while a result still waits in the output register; the engine then stalls
// at its end until that register is free. cfg is always ready.
module nearest_line_projection #(
  parameter int MAX_RAILS  = nlp_pkg::NLP_MAX_RAILS,
  parameter int COORD_BITS = nlp_pkg::NLP_COORD_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [nlp_pkg::NLP_CNT_BITS-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                operation_i,
  input  logic [nlp_pkg::NLP_IDX_BITS-1:0]    rail_index_i,
  input  logic signed [COORD_BITS-1:0]        start_x_i,
  input  logic signed [COORD_BITS-1:0]        start_y_i,
  input  logic signed [COORD_BITS-1:0]        end_x_i,
  input  logic signed [COORD_BITS-1:0]        end_y_i,
  input  logic signed [COORD_BITS-1:0]        point_x_i,
  input  logic signed [COORD_BITS-1:0]        point_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                found_o,
  output logic [nlp_pkg::NLP_IDX_BITS-1:0]    nearest_rail_o,
  output logic signed [COORD_BITS-1:0]        near_x_o,
  output logic signed [COORD_BITS-1:0]        near_y_o,
  output logic                                load_ack_o
);
  import nlp_pkg::*;

  // widths
  localparam int CW   = COORD_BITS;
  localparam int DW   = CW + 1;          // direction and point offset
  localparam int PW   = 2 * CW;          // magnitude of a coordinate product
  localparam int SW   = 2 * CW + 1;      // signed coordinate product
  localparam int CB   = 2 * CW + 1;      // cross magnitude, squared length, dot magnitude
  localparam int AW   = 2 * CB;          // squared cross
  localparam int KW   = AW + CB;         // comparison key
  localparam int NW   = 3 * CW + 1;      // projection numerator and quotient
  localparam int VW   = NW + 2;          // unclamped projected coordinate
  localparam int RAW  = (MAX_RAILS > 1) ? $clog2(MAX_RAILS) : 1;
  localparam int IW   = $clog2(MAX_RAILS + 1);
  localparam int RW   = 2 * CW + 2 * DW;
  localparam int IDXW = NLP_IDX_BITS;

  localparam logic signed [VW-1:0] SAT_TOP = {{(VW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [VW-1:0] SAT_BOT = {{(VW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  typedef enum logic [21:0] {
    S_IDLE   = 22'b0000000000000000000001,
    S_FETCH  = 22'b0000000000000000000010,
    S_LOAD   = 22'b0000000000000000000100,
    S_X1     = 22'b0000000000000000001000,
    S_X2     = 22'b0000000000000000010000,
    S_X3     = 22'b0000000000000000100000,
    S_X4     = 22'b0000000000000001000000,
    S_X5     = 22'b0000000000000010000000,
    S_X6     = 22'b0000000000000100000000,
    S_X7     = 22'b0000000000001000000000,
    S_X8     = 22'b0000000000010000000000,
    S_NEXT   = 22'b0000000000100000000000,
    S_PROJ   = 22'b0000000001000000000000,
    S_P1     = 22'b0000000010000000000000,
    S_P2     = 22'b0000000100000000000000,
    S_P3     = 22'b0000001000000000000000,
    S_PDX    = 22'b0000010000000000000000,
    S_P4     = 22'b0000100000000000000000,
    S_PDY    = 22'b0001000000000000000000,
    S_MUL    = 22'b0010000000000000000000,
    S_DIV    = 22'b0100000000000000000000,
    S_RESULT = 22'b1000000000000000000000
  } state_e;

  // signed product from an unsigned magnitude and a sign
  function automatic logic signed [SW-1:0] signed_prod(input logic neg,
                                                       input logic [PW-1:0] p);
    logic signed [SW-1:0] v;
    v = {1'b0, p};
    return neg ? -v : v;
  endfunction

  // start plus or minus quotient, clamped to the coordinate range
  function automatic logic [CW-1:0] sat_axis(input logic signed [CW-1:0] s,
                                             input logic neg,
                                             input logic [NW-1:0] q);
    logic signed [VW-1:0] v;
    logic signed [VW-1:0] qs;
    qs = signed'({2'b00, q});
    v  = neg ? VW'(s) - qs : VW'(s) + qs;
    if (v > SAT_TOP) begin
      v = SAT_TOP;
    end else if (v < SAT_BOT) begin
      v = SAT_BOT;
    end
    return v[CW-1:0];
  endfunction

  state_e state_q, state_d, ret_q, ret_d;

  logic [NLP_CNT_BITS-1:0] count_q;
  logic signed [CW-1:0] px_q, px_d, py_q, py_d;
  logic [IW-1:0]        n_q, n_d, idx_q, idx_d, idx_nx, limit;
  logic signed [CW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic signed [DW-1:0] dx_q, dx_d, dy_q, dy_d;
  logic signed [SW-1:0] t1_q, t1_d;
  logic [CB-1:0]        c_q, c_d, m_q, m_d, m_sum;
  logic [AW-1:0]        c2_q, c2_d;
  logic [KW-1:0]        kc_q, kc_d;
  logic                 found_q, found_d;
  logic [RAW-1:0]       bidx_q, bidx_d;
  logic [AW-1:0]        bc2_q, bc2_d;
  logic [CB-1:0]        bm_q, bm_d;
  logic signed [CW-1:0] bsx_q, bsx_d, bsy_q, bsy_d;
  logic signed [DW-1:0] bdx_q, bdx_d, bdy_q, bdy_d;
  logic [CB-1:0]        adot_q, adot_d;
  logic [CW-1:0]        nx_q, nx_d, ny_q, ny_d;
  logic                 ack_q, ack_d;

  logic                 out_valid_q, out_valid_d;
  logic                 out_found_q, out_found_d;
  logic [IDXW-1:0]      out_idx_q, out_idx_d;
  logic [CW-1:0]        out_x_q, out_x_d, out_y_q, out_y_d;
  logic                 out_ack_q, out_ack_d;

  // offsets of the query point from the current and the best rail start
  logic signed [DW-1:0] qx_c, qy_c, bqx_c, bqy_c;
  logic [CW-1:0]        mdx, mdy, mqx, mqy, mbdx, mbdy, mbqx, mbqy;
  logic signed [SW:0]   wide_c;
  logic [CB-1:0]        wide_mag;

  // ram and arithmetic units
  logic                 ram_we;
  logic [RAW-1:0]       ram_waddr;
  logic [RW-1:0]        ram_wdata, ram_rdata;
  logic signed [DW-1:0] wdx, wdy;
  logic                 idx_ok;
  logic                 mul_start;
  logic [AW-1:0]        mul_a;
  logic [CB-1:0]        mul_b;
  logic [KW-1:0]        prod;
  logic                 mul_done;
  logic                 div_start;
  logic [NW-1:0]        quo;
  logic                 div_done;

  assign wdx       = DW'(end_x_i) - DW'(start_x_i);
  assign wdy       = DW'(end_y_i) - DW'(start_y_i);
  assign ram_wdata = {start_x_i, start_y_i, wdx, wdy};
  assign ram_waddr = RAW'(rail_index_i);
  assign idx_ok    = 32'(rail_index_i) < 32'(MAX_RAILS);

  // rails beyond the table are never scanned
  assign limit  = (32'(count_q) > 32'(MAX_RAILS)) ? IW'(MAX_RAILS) : IW'(count_q);
  assign idx_nx = idx_q + IW'(1);

  assign qx_c  = DW'(px_q) - DW'(sx_q);
  assign qy_c  = DW'(py_q) - DW'(sy_q);
  assign bqx_c = DW'(px_q) - DW'(bsx_q);
  assign bqy_c = DW'(py_q) - DW'(bsy_q);
  assign mdx   = CW'(dx_q[DW-1] ? -dx_q : dx_q);
  assign mdy   = CW'(dy_q[DW-1] ? -dy_q : dy_q);
  assign mqx   = CW'(qx_c[DW-1] ? -qx_c : qx_c);
  assign mqy   = CW'(qy_c[DW-1] ? -qy_c : qy_c);
  assign mbdx  = CW'(bdx_q[DW-1] ? -bdx_q : bdx_q);
  assign mbdy  = CW'(bdy_q[DW-1] ? -bdy_q : bdy_q);
  assign mbqx  = CW'(bqx_c[DW-1] ? -bqx_c : bqx_c);
  assign mbqy  = CW'(bqy_c[DW-1] ? -bqy_c : bqy_c);
  assign m_sum = m_q + CB'(prod[PW-1:0]);

  nlp_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_RAILS)
  ) u_rail_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q[RAW-1:0]),
    .rdata_o (ram_rdata)
  );

  nlp_mul #(
    .A_W (AW),
    .B_W (CB),
    .DIG (NLP_MUL_DIGIT)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (prod),
    .done_o  (mul_done)
  );

  nlp_div #(
    .N_W (NW),
    .D_W (CB)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod[NW-1:0]),
    .den_i   (bm_q),
    .quo_o   (quo),
    .done_o  (div_done)
  );

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    px_d        = px_q;
    py_d        = py_q;
    n_d         = n_q;
    idx_d       = idx_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    t1_d        = t1_q;
    c_d         = c_q;
    m_d         = m_q;
    c2_d        = c2_q;
    kc_d        = kc_q;
    found_d     = found_q;
    bidx_d      = bidx_q;
    bc2_d       = bc2_q;
    bm_d        = bm_q;
    bsx_d       = bsx_q;
    bsy_d       = bsy_q;
    bdx_d       = bdx_q;
    bdy_d       = bdy_q;
    adot_d      = adot_q;
    nx_d        = nx_q;
    ny_d        = ny_q;
    ack_d       = ack_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_found_d = out_found_q;
    out_idx_d   = out_idx_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_ack_d   = out_ack_q;
    ram_we      = 1'b0;
    mul_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;
    wide_c      = '0;
    wide_mag    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          found_d = 1'b0;
          bidx_d  = '0;
          nx_d    = '0;
          ny_d    = '0;
          if (operation_i == OP_QUERY) begin
            px_d    = point_x_i;
            py_d    = point_y_i;
            n_d     = limit;
            idx_d   = '0;
            ack_d   = 1'b0;
            state_d = (limit == '0) ? S_PROJ : S_FETCH;
          end else begin
            ram_we  = idx_ok;
            ack_d   = idx_ok;
            state_d = S_RESULT;
          end
        end
      end
      // ram address is presented here, word arrives next cycle
      S_FETCH: state_d = S_LOAD;
      S_LOAD: begin
        sx_d    = ram_rdata[RW-1 -: CW];
        sy_d    = ram_rdata[RW-CW-1 -: CW];
        dx_d    = ram_rdata[2*DW-1 -: DW];
        dy_d    = ram_rdata[DW-1:0];
        state_d = S_X1;
      end
      S_X1: begin
        mul_start = 1'b1;
        mul_a     = AW'(mdx);
        mul_b     = CB'(mqy);
        ret_d     = S_X2;
        state_d   = S_MUL;
      end
      S_X2: begin
        t1_d      = signed_prod(dx_q[DW-1] ^ qy_c[DW-1], prod[PW-1:0]);
        mul_start = 1'b1;
        mul_a     = AW'(mdy);
        mul_b     = CB'(mqx);
        ret_d     = S_X3;
        state_d   = S_MUL;
      end
      S_X3: begin
        // cross product dx*qy - dy*qx
        wide_c    = (SW+1)'(t1_q)
                  - (SW+1)'(signed_prod(dy_q[DW-1] ^ qx_c[DW-1], prod[PW-1:0]));
        c_d       = CB'(wide_c[SW] ? -wide_c : wide_c);
        mul_start = 1'b1;
        mul_a     = AW'(mdx);
        mul_b     = CB'(mdx);
        ret_d     = S_X4;
        state_d   = S_MUL;
      end
      S_X4: begin
        m_d       = CB'(prod[PW-1:0]);
        mul_start = 1'b1;
        mul_a     = AW'(mdy);
        mul_b     = CB'(mdy);
        ret_d     = S_X5;
        state_d   = S_MUL;
      end
      S_X5: begin
        m_d = m_sum;
        if (m_sum == '0) begin
          // zero-length rail is skipped
          state_d = S_NEXT;
        end else begin
          mul_start = 1'b1;
          mul_a     = AW'(c_q);
          mul_b     = c_q;
          ret_d     = S_X6;
          state_d   = S_MUL;
        end
      end
      S_X6: begin
        c2_d = prod[AW-1:0];
        if (!found_q) begin
          found_d = 1'b1;
          bidx_d  = idx_q[RAW-1:0];
          bc2_d   = prod[AW-1:0];
          bm_d    = m_q;
          bsx_d   = sx_q;
          bsy_d   = sy_q;
          bdx_d   = dx_q;
          bdy_d   = dy_q;
          state_d = S_NEXT;
        end else begin
          mul_start = 1'b1;
          mul_a     = prod[AW-1:0];
          mul_b     = bm_q;
          ret_d     = S_X7;
          state_d   = S_MUL;
        end
      end
      S_X7: begin
        kc_d      = prod;
        mul_start = 1'b1;
        mul_a     = bc2_q;
        mul_b     = m_q;
        ret_d     = S_X8;
        state_d   = S_MUL;
      end
      S_X8: begin
        // c^2 * m_best <= c_best^2 * m, a tie goes to the later rail
        if (kc_q <= prod) begin
          bidx_d = idx_q[RAW-1:0];
          bc2_d  = c2_q;
          bm_d   = m_q;
          bsx_d  = sx_q;
          bsy_d  = sy_q;
          bdx_d  = dx_q;
          bdy_d  = dy_q;
        end
        state_d = S_NEXT;
      end
      S_NEXT: begin
        idx_d   = idx_nx;
        state_d = (idx_nx == n_q) ? S_PROJ : S_FETCH;
      end
      S_PROJ: begin
        if (!found_q) begin
          state_d = S_RESULT;
        end else begin
          mul_start = 1'b1;
          mul_a     = AW'(mbdx);
          mul_b     = CB'(mbqx);
          ret_d     = S_P1;
          state_d   = S_MUL;
        end
      end
      S_P1: begin
        t1_d      = signed_prod(bdx_q[DW-1] ^ bqx_c[DW-1], prod[PW-1:0]);
        mul_start = 1'b1;
        mul_a     = AW'(mbdy);
        mul_b     = CB'(mbqy);
        ret_d     = S_P2;
        state_d   = S_MUL;
      end
      S_P2: begin
        // dot product dx*qx + dy*qy
        wide_c    = (SW+1)'(t1_q)
                  + (SW+1)'(signed_prod(bdy_q[DW-1] ^ bqy_c[DW-1], prod[PW-1:0]));
        wide_mag  = CB'(wide_c[SW] ? -wide_c : wide_c);
        adot_d    = wide_mag;
        mul_start = 1'b1;
        mul_a     = AW'(mbdx);
        mul_b     = wide_mag;
        ret_d     = S_P3;
        state_d   = S_MUL;
      end
      S_P3: begin
        div_start = 1'b1;
        ret_d     = S_PDX;
        state_d   = S_DIV;
      end
      S_PDX: begin
        nx_d      = sat_axis(bsx_q, bdx_q[DW-1], quo);
        mul_start = 1'b1;
        mul_a     = AW'(mbdy);
        mul_b     = adot_q;
        ret_d     = S_P4;
        state_d   = S_MUL;
      end
      S_P4: begin
        div_start = 1'b1;
        ret_d     = S_PDY;
        state_d   = S_DIV;
      end
      S_PDY: begin
        ny_d    = sat_axis(bsy_q, bdy_q[DW-1], quo);
        state_d = S_RESULT;
      end
      S_MUL: begin
        if (mul_done) begin
          state_d = ret_q;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = ret_q;
        end
      end
      S_RESULT: begin
        // hand over once the output register is free or being emptied
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_found_d = found_q;
          out_idx_d   = IDXW'(bidx_q);
          out_x_d     = nx_q;
          out_y_d     = ny_q;
          out_ack_d   = ack_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      count_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        count_q <= cfg_data_i;
      end
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    px_q      <= px_d;
    py_q      <= py_d;
    n_q       <= n_d;
    idx_q     <= idx_d;
    sx_q      <= sx_d;
    sy_q      <= sy_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    t1_q      <= t1_d;
    c_q       <= c_d;
    m_q       <= m_d;
    c2_q      <= c2_d;
    kc_q      <= kc_d;
    bidx_q    <= bidx_d;
    bc2_q     <= bc2_d;
    bm_q      <= bm_d;
    bsx_q     <= bsx_d;
    bsy_q     <= bsy_d;
    bdx_q     <= bdx_d;
    bdy_q     <= bdy_d;
    adot_q    <= adot_d;
    nx_q      <= nx_d;
    ny_q      <= ny_d;
    ack_q     <= ack_d;
    out_found_q <= out_found_d;
    out_idx_q <= out_idx_d;
    out_x_q   <= out_x_d;
    out_y_q   <= out_y_d;
    out_ack_q <= out_ack_d;
  end

  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign found_o        = out_found_q;
  assign nearest_rail_o = out_idx_q;
  assign near_x_o       = out_x_q;
  assign near_y_o       = out_y_q;
  assign load_ack_o     = out_ack_q;

endmodule
